// ----- design/matrix_multiply_accumulate_defines.svh -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Same-cycle implication
`define MMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Field widths, opcodes, register indexes and the token passed along the cells.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int DIM_LIMIT   = 8;
  localparam int DIM_W       = 4;
  localparam int ROW_W       = 3;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 40;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M  = 2'd0,
    CFG_INNER_K = 2'd1,
    CFG_COLS_N  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [ACC_W-1:0] acc;
  } mma_token_t;

  // Clamp a dimension register to the number of cells
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] cap);
    return (r > cap) ? cap : r;
  endfunction

endpackage

// ----- design/mma_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mma_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate cell
// Holds column CELL_IDX of A and row CELL_IDX of B; if CELL_IDX < k, adds one
// saturated product to each passing accumulator, and hands it on registered.
// ----------------------------------------------------------------------------
module mma_cell import mma_pkg::*; #(
  parameter int DIM_CAP  = DIM_LIMIT,
  parameter int CELL_IDX = 0,
  parameter int AW       = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_a_en,
  input  logic             wr_b_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic [DIM_W-1:0] eff_k,
  input  mma_token_t       tok_in,
  output mma_token_t       tok_out
);

  logic signed [VAL_W-1:0]  a_q;
  logic signed [VAL_W-1:0]  b_q;
  mma_token_t               s1_tok_r;
  mma_token_t               s2_tok_r;
  mma_token_t               out_tok_r;
  mma_token_t               out_tok_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     active;

  // A column store, indexed by row
  mma_ram #(.WIDTH(VAL_W), .DEPTH(DIM_CAP), .ADDR_W(AW)) u_a_ram (
    .clk   (clk),
    .we    (wr_a_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (tok_in.row[AW-1:0]),
    .rdata (a_q)
  );

  // B row store, indexed by column
  mma_ram #(.WIDTH(VAL_W), .DEPTH(DIM_CAP), .ADDR_W(AW)) u_b_ram (
    .clk   (clk),
    .we    (wr_b_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (tok_in.col[AW-1:0]),
    .rdata (b_q)
  );

  assign active = (DIM_W'(CELL_IDX) < eff_k);

  // Saturate the product into the accumulator, or pass it beyond k
  always_comb begin
    sum = {s2_tok_r.acc[ACC_W-1], s2_tok_r.acc}
        + {{(ACC_W + 1 - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (!active) begin
      acc_nxt = s2_tok_r.acc;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
    out_tok_nxt     = s2_tok_r;
    out_tok_nxt.acc = acc_nxt;
  end

  // Advance token through read, multiply and add stages
  always_ff @(posedge clk) begin
    prod_r <= a_q * b_q;
    if (!rst_n) begin
      s1_tok_r  <= '0;
      s2_tok_r  <= '0;
      out_tok_r <= '0;
    end else begin
      s1_tok_r  <= tok_in;
      s2_tok_r  <= s1_tok_r;
      out_tok_r <= out_tok_nxt;
    end
  end

  assign tok_out = out_tok_r;

endmodule

// ----- design/matrix_multiply_accumulate.sv -----
`timescale 1ns / 1ps
// Load requests leave busy low; they are taken only while idle.
// Compute: C entries enter the cell chain one per cycle; results leave its
// tail in the same order, one per cycle, after a delay set by the chain depth.
// Results cannot be stalled. Synchronous reset clears control and dimension
// registers (to 8); the A, B and C stores keep whatever they held.
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate top level
// C = C + A * B over a chain of multiply-accumulate cells, one per inner index.
// ----------------------------------------------------------------------------
`include "matrix_multiply_accumulate_defines.svh"

module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_operand_value,
  input  logic signed [ACC_W-1:0] in_accum_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_row,
  output logic [ROW_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] out_value,
  output logic                    out_last
);

  localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
  localparam int AW      = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
  localparam int C_DEPTH = DIM_CAP * DIM_CAP;
  localparam int CAW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] rows_m_r, inner_k_r, cols_n_r;
  logic [DIM_W-1:0] eff_m, eff_k, eff_n;
  logic [ROW_W-1:0] i_r, i_nxt, j_r, j_nxt;
  mma_token_t       tok0_r, tok0_nxt;
  mma_token_t       chain [DIM_CAP+1];
  mma_token_t       tail;
  logic             accept, ld_ok, ld_a, ld_b, ld_c, cmp_go, issue_last;
  logic [AW-1:0]    cell_waddr;
  logic             c_we;
  logic [CAW-1:0]   c_waddr, c_raddr;
  logic [ACC_W-1:0] c_wdata, c_q;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign ld_ok     = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign ld_a      = accept && ld_ok && (in_opcode == OP_LOAD_A);
  assign ld_b      = accept && ld_ok && (in_opcode == OP_LOAD_B);
  assign ld_c      = accept && ld_ok && (in_opcode == OP_LOAD_C);

  assign eff_m = eff_dim(rows_m_r,  DIM_W'(DIM_CAP));
  assign eff_k = eff_dim(inner_k_r, DIM_W'(DIM_CAP));
  assign eff_n = eff_dim(cols_n_r,  DIM_W'(DIM_CAP));

  assign cmp_go     = accept && (in_opcode == OP_COMPUTE) && (eff_m != '0) && (eff_n != '0);
  assign issue_last = (DIM_W'(i_r) == eff_m - 1'b1) && (DIM_W'(j_r) == eff_n - 1'b1);

  // Write dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_W'(DIM_LIMIT);
      inner_k_r <= DIM_W'(DIM_LIMIT);
      cols_n_r  <= DIM_W'(DIM_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_M:  rows_m_r  <= cfg_data;
        CFG_INNER_K: inner_k_r <= cfg_data;
        CFG_COLS_N:  cols_n_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence C entries into the chain in row-major order
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    tok0_nxt       = '0;
    tok0_nxt.row   = i_r;
    tok0_nxt.col   = j_r;
    tok0_nxt.last  = issue_last;
    case (state_r)
      ST_IDLE: begin
        if (cmp_go) begin
          state_nxt = ST_ISSUE;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        tok0_nxt.valid = 1'b1;
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end else if (DIM_W'(j_r) == eff_n - 1'b1) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (tail.valid && tail.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tok0_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tok0_r  <= tok0_nxt;
    end
  end

  // C store: loads and write-back share the port, never at once
  assign c_raddr = CAW'(int'(i_r) * DIM_CAP + int'(j_r));
  assign c_we    = ld_c || tail.valid;
  assign c_waddr = tail.valid ? CAW'(int'(tail.row) * DIM_CAP + int'(tail.col))
                              : CAW'(int'(in_row) * DIM_CAP + int'(in_col));
  assign c_wdata = tail.valid ? tail.acc : in_accum_value;

  mma_ram #(.WIDTH(ACC_W), .DEPTH(C_DEPTH), .ADDR_W(CAW)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  // Feed the chain with the starting C entry
  always_comb begin
    chain[0]     = tok0_r;
    chain[0].acc = c_q;
  end

  assign cell_waddr = (in_opcode == OP_LOAD_A) ? in_row[AW-1:0] : in_col[AW-1:0];

  for (genvar c = 0; c < DIM_CAP; c++) begin : g_cell
    mma_cell #(.DIM_CAP(DIM_CAP), .CELL_IDX(c), .AW(AW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_a_en (ld_a && (in_col == ROW_W'(c))),
      .wr_b_en (ld_b && (in_row == ROW_W'(c))),
      .wr_addr (cell_waddr),
      .wr_data (in_operand_value),
      .eff_k   (eff_k),
      .tok_in  (chain[c]),
      .tok_out (chain[c+1])
    );
  end

  assign tail      = chain[DIM_CAP];
  assign out_valid = tail.valid;
  assign out_row   = tail.row;
  assign out_col   = tail.col;
  assign out_value = tail.acc;
  assign out_last  = tail.last;

  // Checks
  `MMA_ASSERT_IMPL(a_out_when_busy, out_valid, busy, "result outside a compute")
  `MMA_ASSERT_NEXT(a_cmp_busy, cmp_go, busy, "compute request did not raise busy")
  `MMA_ASSERT_NEXT(a_last_idle, out_valid && out_last, !busy, "busy held after last result")
  `MMA_ASSERT_NEXT(a_mid_busy, out_valid && !out_last, busy, "busy dropped before last result")

endmodule
